FILE: hw/rtl/trh_pkg.sv
// ----------------------------------------------------------------------------
// trh_pkg
// Types and constants shared by the IPv4/TCP reset header builder: the
// transfer structs of the input and result channels, the header word
// positions, the pipeline constants and the fixed header field values.
// ----------------------------------------------------------------------------
package trh_pkg;

  // One connection tuple, transferred on the input channel.
  typedef struct packed {
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic [31:0] sequence_number;
    logic [15:0] ip_ident;
  } hdr_in_t;

  // One header word, transferred on the result channel.
  typedef struct packed {
    logic [31:0] header_word;
    logic [3:0]  word_index;
    logic        last_word;
  } hdr_out_t;

  // Word positions within the 40-byte header.
  localparam logic [3:0] WORD_VER_LEN  = 4'd0;
  localparam logic [3:0] WORD_IDENT    = 4'd1;
  localparam logic [3:0] WORD_TTL_CSUM = 4'd2;
  localparam logic [3:0] WORD_SADDR    = 4'd3;
  localparam logic [3:0] WORD_DADDR    = 4'd4;
  localparam logic [3:0] WORD_PORTS    = 4'd5;
  localparam logic [3:0] WORD_SEQ      = 4'd6;
  localparam logic [3:0] WORD_ACK      = 4'd7;
  localparam logic [3:0] WORD_FLAGS    = 4'd8;
  localparam logic [3:0] WORD_TCP_CSUM = 4'd9;
  localparam logic [3:0] WORD_LAST     = WORD_TCP_CSUM;

  // Checksum pipeline depth ahead of the word serializer.
  localparam logic [3:0] PIPE_DEPTH    = 4'd3;
  // Serializer index from which a new tuple may be taken.
  localparam logic [3:0] ACCEPT_IDX    = WORD_LAST - PIPE_DEPTH;

  // Fixed header fields.
  localparam logic [7:0]  VER_IHL      = 8'h45;
  localparam logic [15:0] TOTAL_LEN    = 16'd40;
  localparam logic [7:0]  PROTO_TCP    = 8'd6;
  localparam logic [15:0] TCP_LEN      = 16'd20;
  localparam logic [7:0]  DATA_OFFSET  = 8'h50;
  localparam logic [7:0]  RST_FLAG     = 8'h04;
  localparam logic [7:0]  TTL_RESET    = 8'd64;

endpackage

FILE: hw/rtl/tcp_reset_header_builder.sv
// ----------------------------------------------------------------------------
// tcp_reset_header_builder
// Builds a 40-byte IPv4 + TCP reset header from a connection tuple and
// sends it as ten big-endian 32-bit words, with both checksums filled in.
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------
//   input    | start / busy         | in_data   (hdr_in_t)
//   result   | out_valid (strobe)   | out_data  (hdr_out_t)
//   config   | cfg_wr_en            | cfg_wr_data (time to live)
//
// A tuple passes through the checksum pipeline and then the word serializer,
// which sends one word per cycle. The serializer sets the rate: a new tuple
// is taken while the previous header is still being sent, and words of
// consecutive tuples follow with no gap.
// Reset is synchronous (rst_n low); time to live resets to 64.
// The receiver cannot stall; busy throttles the sender instead.
// ----------------------------------------------------------------------------
module tcp_reset_header_builder (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  trh_pkg::hdr_in_t in_data,
  output logic             out_valid,
  output trh_pkg::hdr_out_t out_data,
  input  logic             cfg_wr_en,
  input  logic [7:0]       cfg_wr_data
);
  import trh_pkg::*;

  // Configuration register.
  logic [7:0] ttl_r;

  // Stage 1: partial sums.
  logic        s1_valid_r;
  hdr_in_t     s1_tup_r;
  logic [7:0]  s1_ttl_r;
  logic [17:0] s1_ip_part_r;
  logic [17:0] s1_addr_sum_r;
  logic [18:0] s1_tcp_part_r;

  // Stage 2: totals, folded once.
  logic        s2_valid_r;
  hdr_in_t     s2_tup_r;
  logic [7:0]  s2_ttl_r;
  logic [16:0] s2_ip_fold_r;
  logic [16:0] s2_tcp_fold_r;

  // Stage 3: final checksums.
  logic        s3_valid_r;
  hdr_in_t     s3_tup_r;
  logic [7:0]  s3_ttl_r;
  logic [15:0] s3_ip_csum_r;
  logic [15:0] s3_tcp_csum_r;

  // Serializer.
  logic        ser_valid_r;
  logic        ser_valid_nxt;
  logic [3:0]  ser_idx_r;
  logic [3:0]  ser_idx_nxt;
  hdr_in_t     ser_tup_r;
  logic [7:0]  ser_ttl_r;
  logic [15:0] ser_ip_csum_r;
  logic [15:0] ser_tcp_csum_r;

  logic        in_xfer;
  logic [19:0] ip_total;
  logic [19:0] tcp_total;
  logic [16:0] ip_fold2;
  logic [16:0] tcp_fold2;
  logic [31:0] word;

  // Only one tuple may be in the checksum pipeline, and it must not reach the
  // serializer before the previous header sends its last word.
  assign busy    = s1_valid_r || s2_valid_r || s3_valid_r ||
                   (ser_valid_r && (ser_idx_r < ACCEPT_IDX));
  assign in_xfer = start && !busy;

  // Time-to-live register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ttl_r <= TTL_RESET;
    end else if (cfg_wr_en) begin
      ttl_r <= cfg_wr_data;
    end
  end

  // Valid bits of the checksum pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_xfer;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  // Stage 1 payload: sums of the IPv4 fields, the addresses and the TCP fields.
  always_ff @(posedge clk) begin
    s1_tup_r      <= in_data;
    s1_ttl_r      <= ttl_r;
    s1_ip_part_r  <= {2'b0, VER_IHL, 8'h00} + {2'b0, TOTAL_LEN}
                   + {2'b0, in_data.ip_ident} + {2'b0, ttl_r, PROTO_TCP};
    s1_addr_sum_r <= {2'b0, in_data.source_address[31:16]}
                   + {2'b0, in_data.source_address[15:0]}
                   + {2'b0, in_data.destination_address[31:16]}
                   + {2'b0, in_data.destination_address[15:0]};
    s1_tcp_part_r <= {3'b0, in_data.source_port} + {3'b0, in_data.destination_port}
                   + {3'b0, in_data.sequence_number[31:16]}
                   + {3'b0, in_data.sequence_number[15:0]}
                   + {11'b0, PROTO_TCP} + {3'b0, TCP_LEN}
                   + {3'b0, DATA_OFFSET, RST_FLAG};
  end

  // Stage 2: add the address sum to both totals and fold once.
  assign ip_total  = {2'b0, s1_ip_part_r} + {2'b0, s1_addr_sum_r};
  assign tcp_total = {1'b0, s1_tcp_part_r} + {2'b0, s1_addr_sum_r};

  always_ff @(posedge clk) begin
    s2_tup_r      <= s1_tup_r;
    s2_ttl_r      <= s1_ttl_r;
    s2_ip_fold_r  <= {1'b0, ip_total[15:0]} + {13'b0, ip_total[19:16]};
    s2_tcp_fold_r <= {1'b0, tcp_total[15:0]} + {13'b0, tcp_total[19:16]};
  end

  // Stage 3: second fold cannot carry again; invert to get the checksum.
  assign ip_fold2  = {1'b0, s2_ip_fold_r[15:0]} + {16'b0, s2_ip_fold_r[16]};
  assign tcp_fold2 = {1'b0, s2_tcp_fold_r[15:0]} + {16'b0, s2_tcp_fold_r[16]};

  always_ff @(posedge clk) begin
    s3_tup_r      <= s2_tup_r;
    s3_ttl_r      <= s2_ttl_r;
    s3_ip_csum_r  <= ~ip_fold2[15:0];
    s3_tcp_csum_r <= ~tcp_fold2[15:0];
  end

  // Serializer control: load a finished header, else step through the words.
  always_comb begin
    ser_valid_nxt = ser_valid_r;
    ser_idx_nxt   = ser_idx_r;
    if (s3_valid_r) begin
      ser_valid_nxt = 1'b1;
      ser_idx_nxt   = WORD_VER_LEN;
    end else if (ser_valid_r && (ser_idx_r == WORD_LAST)) begin
      ser_valid_nxt = 1'b0;
    end else if (ser_valid_r) begin
      ser_idx_nxt   = ser_idx_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_valid_r <= 1'b0;
      ser_idx_r   <= WORD_VER_LEN;
    end else begin
      ser_valid_r <= ser_valid_nxt;
      ser_idx_r   <= ser_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_valid_r) begin
      ser_tup_r      <= s3_tup_r;
      ser_ttl_r      <= s3_ttl_r;
      ser_ip_csum_r  <= s3_ip_csum_r;
      ser_tcp_csum_r <= s3_tcp_csum_r;
    end
  end

  // Word selection.
  always_comb begin
    unique case (ser_idx_r)
      WORD_VER_LEN:  word = {VER_IHL, 8'h00, TOTAL_LEN};
      WORD_IDENT:    word = {ser_tup_r.ip_ident, 16'h0000};
      WORD_TTL_CSUM: word = {ser_ttl_r, PROTO_TCP, ser_ip_csum_r};
      WORD_SADDR:    word = ser_tup_r.source_address;
      WORD_DADDR:    word = ser_tup_r.destination_address;
      WORD_PORTS:    word = {ser_tup_r.source_port, ser_tup_r.destination_port};
      WORD_SEQ:      word = ser_tup_r.sequence_number;
      WORD_ACK:      word = 32'h0000_0000;
      WORD_FLAGS:    word = {DATA_OFFSET, RST_FLAG, 16'h0000};
      WORD_TCP_CSUM: word = {ser_tcp_csum_r, 16'h0000};
      default:       word = 32'h0000_0000;
    endcase
  end

  // Result transfer.
  assign out_valid            = ser_valid_r;
  assign out_data.header_word = word;
  assign out_data.word_index  = ser_idx_r;
  assign out_data.last_word   = (ser_idx_r == WORD_LAST);

`ifndef ASSERT_OFF
  // A finished header never overwrites one still being sent.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    s3_valid_r |-> (!ser_valid_r || (ser_idx_r == WORD_LAST)))
    else $error("header loaded while serializer busy");

  // The checksum pipeline holds at most one tuple.
  a_one_in_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({s1_valid_r, s2_valid_r, s3_valid_r}) <= 1)
    else $error("more than one tuple in checksum pipeline");

  // Words of one header follow each other without gaps.
  a_word_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.word_index != WORD_LAST)) |=>
      (out_valid && (out_data.word_index == $past(out_data.word_index) + 4'd1)))
    else $error("header words not contiguous");

  // An accepted tuple starts its header after the pipeline latency.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |-> ##4 (out_valid && (out_data.word_index == WORD_VER_LEN)))
    else $error("header did not start on time");
`endif

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the IPv4/TCP reset header builder. Connection
// tuples go in as bursts with random gaps, under several time-to-live
// settings. A header predictor works out the ten words each accepted tuple
// must produce, and every word on the result strobe is checked field by
// field against the oldest word still outstanding.
// ----------------------------------------------------------------------------

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import trh_pkg::*;

  // Predicts the header words of each accepted tuple and checks the words
  // that come out of the block in order.
  class rst_header_checker;
    logic [7:0]          ttl;
    trh_pkg::hdr_out_t   expected_words[$];
    int                  mismatch_count;

    function new();
      ttl            = trh_pkg::TTL_RESET;
      mismatch_count = 0;
    endfunction

    // Folds the carries of a halfword sum back into the low 16 bits.
    static function logic [15:0] fold16(logic [31:0] s);
      while (s[31:16] != 16'h0000) begin
        s = s[15:0] + s[31:16];
      end
      return s[15:0];
    endfunction

    function void set_ttl(logic [7:0] value);
      ttl = value;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    // Builds the full header for one tuple and queues its ten words.
    function void note_tuple(trh_pkg::hdr_in_t t);
      logic [31:0]       w [10];
      logic [31:0]       sum;
      trh_pkg::hdr_out_t e;

      w[trh_pkg::WORD_VER_LEN]  = {trh_pkg::VER_IHL, 8'h00, trh_pkg::TOTAL_LEN};
      w[trh_pkg::WORD_IDENT]    = {t.ip_ident, 16'h0000};
      w[trh_pkg::WORD_TTL_CSUM] = {ttl, trh_pkg::PROTO_TCP, 16'h0000};
      w[trh_pkg::WORD_SADDR]    = t.source_address;
      w[trh_pkg::WORD_DADDR]    = t.destination_address;

      // The IP checksum covers the five words of the IPv4 header.
      sum = 32'h0;
      for (int k = 0; k < 5; k++) begin
        sum = sum + w[k][31:16] + w[k][15:0];
      end
      w[trh_pkg::WORD_TTL_CSUM][15:0] = ~fold16(sum);

      w[trh_pkg::WORD_PORTS]    = {t.source_port, t.destination_port};
      w[trh_pkg::WORD_SEQ]      = t.sequence_number;
      w[trh_pkg::WORD_ACK]      = 32'h0;
      w[trh_pkg::WORD_FLAGS]    = {trh_pkg::DATA_OFFSET, trh_pkg::RST_FLAG, 16'h0000};
      w[trh_pkg::WORD_TCP_CSUM] = 32'h0;

      // The TCP checksum adds the pseudo-header to the five TCP words.
      sum = t.source_address[31:16] + t.source_address[15:0]
          + t.destination_address[31:16] + t.destination_address[15:0]
          + trh_pkg::PROTO_TCP + trh_pkg::TCP_LEN;
      for (int k = 5; k < 10; k++) begin
        sum = sum + w[k][31:16] + w[k][15:0];
      end
      w[trh_pkg::WORD_TCP_CSUM][31:16] = ~fold16(sum);

      for (int k = 0; k < 10; k++) begin
        e.header_word = w[k];
        e.word_index  = 4'(k);
        e.last_word   = (4'(k) == trh_pkg::WORD_LAST);
        expected_words.push_back(e);
      end
    endfunction

    // Compares one transferred word with the oldest outstanding word.
    function void check_word(trh_pkg::hdr_out_t got);
      trh_pkg::hdr_out_t e;

      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual %h", $time, got);
        mismatch_count++;
        return;
      end
      e = expected_words.pop_front();
      if (got.header_word !== e.header_word) begin
        $display("%0t: word %0d header_word: expected %h, actual %h",
                 $time, e.word_index, e.header_word, got.header_word);
        mismatch_count++;
      end
      if (got.word_index !== e.word_index) begin
        $display("%0t: word_index: expected %0d, actual %0d",
                 $time, e.word_index, got.word_index);
        mismatch_count++;
      end
      if (got.last_word !== e.last_word) begin
        $display("%0t: word %0d last_word: expected %b, actual %b",
                 $time, e.word_index, e.last_word, got.last_word);
        mismatch_count++;
      end
    endfunction
  endclass

  logic       clk         = 1'b0;
  logic       rst_n       = 1'b0;
  logic       start       = 1'b0;
  logic       busy;
  hdr_in_t    in_data     = '0;
  logic       out_valid;
  hdr_out_t   out_data;
  logic       cfg_wr_en   = 1'b0;
  logic [7:0] cfg_wr_data = 8'h00;

  rst_header_checker sb;

  tcp_reset_header_builder dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watch both channels: note every tuple transfer and check every word.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        sb.note_tuple(in_data);
      end
      if (out_valid === 1'b1) begin
        sb.check_word(out_data);
      end
    end
  end

  function automatic hdr_in_t make_tuple(logic [31:0] saddr, logic [31:0] daddr,
                                         logic [15:0] sport, logic [15:0] dport,
                                         logic [31:0] seq, logic [15:0] ident);
    hdr_in_t t;
    t.source_address      = saddr;
    t.destination_address = daddr;
    t.source_port         = sport;
    t.destination_port    = dport;
    t.sequence_number     = seq;
    t.ip_ident            = ident;
    return t;
  endfunction

  // Zero, all ones or a random value, equally often.
  function automatic logic [31:0] pick_edge32();
    case ($urandom_range(0, 2))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Random tuple; some have fields at their extremes and some are tuned so
  // that a checksum sum folds to all ones, which makes the checksum zero.
  function automatic hdr_in_t random_tuple();
    hdr_in_t     t;
    int          kind;
    logic [31:0] rest;

    kind = $urandom_range(0, 9);
    t = make_tuple($urandom(), $urandom(), 16'($urandom()), 16'($urandom()),
                   $urandom(), 16'($urandom()));
    if (kind == 6) begin
      t = make_tuple(pick_edge32(), pick_edge32(), 16'(pick_edge32()),
                     16'(pick_edge32()), pick_edge32(), 16'(pick_edge32()));
    end
    if (kind == 7 || kind == 9) begin
      rest = {VER_IHL, 8'h00} + TOTAL_LEN + {sb.ttl, PROTO_TCP}
           + t.source_address[31:16] + t.source_address[15:0]
           + t.destination_address[31:16] + t.destination_address[15:0];
      t.ip_ident = 16'hFFFF - sb.fold16(rest);
    end
    if (kind == 8 || kind == 9) begin
      rest = t.source_address[31:16] + t.source_address[15:0]
           + t.destination_address[31:16] + t.destination_address[15:0]
           + PROTO_TCP + TCP_LEN + t.destination_port
           + t.sequence_number[31:16] + t.sequence_number[15:0]
           + {DATA_OFFSET, RST_FLAG};
      t.source_port = 16'hFFFF - sb.fold16(rest);
    end
    return t;
  endfunction

  // Offers one tuple and returns at the edge where it is transferred.
  // Start stays high so that the next tuple of a burst can follow at once.
  task automatic send_tuple(hdr_in_t t);
    in_data <= t;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
  endtask

  // Random tuples in bursts of random length with random gaps between.
  task automatic send_random(int count);
    int left;
    int burst;
    int gap;

    left = count;
    while (left > 0) begin
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 5);
      for (int i = 0; i < burst && left > 0; i++) begin
        send_tuple(random_tuple());
        left--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    start <= 1'b0;
  endtask

  // Waits until every predicted word has been transferred. The first edge
  // lets the monitor note a tuple transferred in this same time step.
  task automatic wait_drained();
    @(posedge clk);
    while (sb.pending() != 0) begin
      @(posedge clk);
    end
  endtask

  // Writes the time to live once the block has gone idle.
  task automatic write_ttl(logic [7:0] value);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    sb.set_ttl(value);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    hdr_in_t    directed[$];
    logic [7:0] ttl_plan[$];

    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed tuples at the reset time to live, sent back to back.
    directed.push_back(make_tuple(32'h0, 32'h0, 16'h0, 16'h0, 32'h0, 16'h0));
    directed.push_back(make_tuple('1, '1, '1, '1, '1, '1));
    // Both checksum sums fold to all ones, so both checksums come out zero.
    directed.push_back(make_tuple(32'h0, 32'h0, 16'hAFE1, 16'h0, 32'h0, 16'h7AD1));
    directed.push_back(make_tuple(32'hAAAA_AAAA, 32'h5555_5555, 16'hAAAA, 16'h5555,
                                  32'hAAAA_AAAA, 16'h5555));
    directed.push_back(make_tuple(32'h5555_5555, 32'hAAAA_AAAA, 16'h5555, 16'hAAAA,
                                  32'h5555_5555, 16'hAAAA));
    directed.push_back(make_tuple(32'hFFFF_FFFF, 32'h0, 16'h0, 16'h0, 32'h0, 16'h0));
    directed.push_back(make_tuple(32'h0, 32'hFFFF_FFFF, 16'h0, 16'h0, 32'h0, 16'h0));
    directed.push_back(make_tuple(32'h0, 32'h0, 16'h0, 16'h0, 32'hFFFF_FFFF, 16'h0));
    directed.push_back(make_tuple(32'h0, 32'h0, 16'hFFFF, 16'hFFFF, 32'h0, 16'h0));
    directed.push_back(make_tuple(32'h0, 32'h0, 16'h0, 16'h0, 32'h0, 16'hFFFF));
    directed.push_back(make_tuple(32'h8000_0000, 32'h0000_0001, 16'h8000, 16'h0001,
                                  32'h8000_0001, 16'h8000));
    directed.push_back(make_tuple(32'hC0A8_0001, 32'h0A00_0002, 16'd443, 16'd51514,
                                  32'h1234_5678, 16'h0BAD));
    foreach (directed[i]) begin
      send_tuple(directed[i]);
    end
    start <= 1'b0;
    send_random(20);

    // Random phases under several time-to-live settings, extremes included.
    ttl_plan = '{8'd255, 8'd0, 8'($urandom()), 8'd1, 8'($urandom()), 8'd128};
    foreach (ttl_plan[i]) begin
      write_ttl(ttl_plan[i]);
      send_random(58);
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

FILE: tcp_reset_header_builder.f
hw/rtl/trh_pkg.sv
hw/rtl/tcp_reset_header_builder.sv
bench/tb_top.sv
